>>> rtl/core/gbts_pkg.sv
// shared types and constants for the gap buffer text store
package gbts_pkg;

  localparam int KIND_W     = 3;
  localparam int POS_W      = 13;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_MOVE      = 3'd0,
    KIND_INSERT    = 3'd1,
    KIND_BACKSPACE = 3'd2,
    KIND_REMOVE    = 3'd3,
    KIND_READ      = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/gbts_ram.sv
// generic single-write, single-read ram with registered read data
module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/gap_buffer_text_store.sv
// gap buffer text store: sequencer, gap pointers and text ram
//
//  channel  | direction | content
//  s_axis   | in        | kind, position, count, in_byte
//  m_axis   | out       | status, out_byte, text_length, cursor
//
// each item is latched on accept and run in ST_EXEC; a read then passes through ST_READ
// for the registered ram data, and a cursor move or remove range shifts the gap in ST_SHIFT:
// one byte crosses the gap per cycle through the single ram port pair, and the last byte
// read lands before the item goes to ST_DONE and from there into the output register
// rst clears the gap pointers and the handshake; the text ram is not cleared
// s_axis_tready is high only while no item is in work; a stalled result waits in the
// output register while the next item is taken
module gap_buffer_text_store #(
  parameter int CAPACITY = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // kind[2:0], position[15:3], count[28:16], in_byte[36:29], zero fill
  input  logic [gbts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status[1:0], out_byte[9:2], text_length[22:10], cursor[35:23], zero fill
  output logic [gbts_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import gbts_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int GW = $clog2(CAPACITY + 1);
  localparam int CW = ((GW > POS_W) ? GW : POS_W) + 1;
  localparam logic [CW-1:0] CAP_W   = CW'(CAPACITY);
  localparam logic [GW-1:0] CAP_G   = GW'(CAPACITY);

  state_t             state, state_next;
  logic [GW-1:0]      gap_head, gap_head_next;
  logic [GW-1:0]      gap_end, gap_end_next;
  kind_t              kind;
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   count;
  logic [BYTE_W-1:0]  in_byte;
  logic               pend, pend_next;
  logic [AW-1:0]      wr_addr, wr_addr_next;
  status_t            res_status, res_status_next;
  logic [BYTE_W-1:0]  res_byte, res_byte_next;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  logic [CW-1:0]      gs_w, ge_w, len_w, pos_w, cnt_w, idx_w;
  logic [GW-1:0]      gs_dec, ge_dec;
  logic               accept, out_free;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign gs_w   = CW'(gap_head);
  assign ge_w   = CW'(gap_end);
  assign pos_w  = CW'(position);
  assign cnt_w  = CW'(count);
  assign len_w  = gs_w + CAP_W - ge_w;
  // physical index of a character behind the gap
  assign idx_w  = pos_w + (ge_w - gs_w);
  assign gs_dec = gap_head - 1'b1;
  assign ge_dec = gap_end - 1'b1;

  gbts_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      gap_head <= '0;
      gap_end  <= CAP_G;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      gap_head <= gap_head_next;
      gap_end  <= gap_end_next;
      pend     <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr    <= wr_addr_next;
    res_status <= res_status_next;
    res_byte   <= res_byte_next;
    if (accept) begin
      kind     <= kind_t'(s_axis_tdata[2:0]);
      position <= s_axis_tdata[15:3];
      count    <= s_axis_tdata[28:16];
      in_byte  <= s_axis_tdata[36:29];
    end
  end

  always_comb begin
    state_next      = state;
    gap_head_next   = gap_head;
    gap_end_next    = gap_end;
    pend_next       = 1'b0;
    wr_addr_next    = wr_addr;
    res_status_next = res_status;
    res_byte_next   = res_byte;
    ram_we          = 1'b0;
    ram_waddr       = wr_addr;
    ram_wdata       = ram_rdata;
    ram_raddr       = '0;
    s_axis_tready   = (state == ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_status_next = STAT_OK;
        res_byte_next   = '0;
        state_next      = ST_DONE;
        unique case (kind)
          KIND_MOVE: begin
            if (pos_w > len_w) begin
              res_status_next = STAT_RANGE;
            end else begin
              state_next = ST_SHIFT;
            end
          end
          KIND_INSERT: begin
            if (len_w == CAP_W) begin
              res_status_next = STAT_FULL;
            end else begin
              ram_we        = 1'b1;
              ram_waddr     = gap_head[AW-1:0];
              ram_wdata     = in_byte;
              gap_head_next = gap_head + 1'b1;
            end
          end
          KIND_BACKSPACE: begin
            if (gap_head != '0) begin
              gap_head_next = gs_dec;
            end
          end
          KIND_REMOVE: begin
            if (pos_w > len_w || cnt_w > len_w - pos_w) begin
              res_status_next = STAT_RANGE;
            end else begin
              state_next = ST_SHIFT;
            end
          end
          KIND_READ: begin
            if (pos_w < len_w) begin
              ram_raddr  = (pos_w < gs_w) ? pos_w[AW-1:0] : idx_w[AW-1:0];
              state_next = ST_READ;
            end
          end
          default: begin
            res_status_next = STAT_RANGE;
          end
        endcase
      end
      ST_SHIFT: begin
        // the byte read last cycle lands on the far side of the gap
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr;
          ram_wdata = ram_rdata;
        end
        if (pos_w < gs_w) begin
          ram_raddr     = gs_dec[AW-1:0];
          wr_addr_next  = ge_dec[AW-1:0];
          gap_head_next = gs_dec;
          gap_end_next  = ge_dec;
          pend_next     = 1'b1;
        end else if (pos_w > gs_w) begin
          ram_raddr     = gap_end[AW-1:0];
          wr_addr_next  = gap_head[AW-1:0];
          gap_head_next = gap_head + 1'b1;
          gap_end_next  = gap_end + 1'b1;
          pend_next     = 1'b1;
        end else if (!pend) begin
          if (kind == KIND_REMOVE) begin
            gap_end_next = GW'(ge_w + cnt_w);
          end
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        res_byte_next = ram_rdata;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= {4'b0000, gs_w[POS_W-1:0], len_w[POS_W-1:0], res_byte, res_status};
    end
  end

endmodule

>>> rtl/core/gbts_checker.sv
// port-level checks for the gap buffer text store and their binding
module gbts_checker #(
  parameter int CAPACITY = 4096
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [gbts_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import gbts_pkg::*;

  localparam logic [POS_W-1:0] LEN_FULL = POS_W'(CAPACITY);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while an item is in work");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_cursor_in_text: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[35:23] <= m_axis_tdata[22:10] || CAPACITY > 8191)
    else $error("cursor beyond text length");

  a_full_length: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == STAT_FULL |-> m_axis_tdata[22:10] == LEN_FULL)
    else $error("full status with text shorter than capacity");

endmodule

bind gap_buffer_text_store gbts_checker #(.CAPACITY(CAPACITY)) u_gbts_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// testbench for the gap buffer text store: edit stream checked against a behavioral text model
module tb_top;
  import gbts_pkg::*;

  localparam int CAP         = 4096;
  localparam int FILL_LEN    = 400;
  localparam int N_RANDOM    = 600;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AFTER  = 300;
  localparam int DRAIN_WAIT  = 50;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  count;
    logic [BYTE_W-1:0] in_byte;
  } edit_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  text_length;
    logic [POS_W-1:0]  cursor;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  edit_t       edit_q[$];
  reply_t      reply_q[$];
  edit_t       edit_on_bus;
  int unsigned tx_idle_pct = 17;
  int unsigned rx_idle_pct = 81;
  int unsigned n_replies = 0;
  int unsigned n_fail = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // text model: bytes before the cursor at [0, gap_lo), after it at [gap_hi, CAP)
  logic [7:0]  text_mem [CAP];
  int unsigned gap_lo = 0;
  int unsigned gap_hi = CAP;

  gap_buffer_text_store #(.CAPACITY(CAP)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  function automatic int unsigned text_len();
    return gap_lo + CAP - gap_hi;
  endfunction

  function automatic void slide_gap(int unsigned target);
    while (target < gap_lo) begin
      gap_lo--;
      gap_hi--;
      text_mem[gap_hi] = text_mem[gap_lo];
    end
    while (target > gap_lo) begin
      text_mem[gap_lo] = text_mem[gap_hi];
      gap_lo++;
      gap_hi++;
    end
  endfunction

  function automatic reply_t apply_edit(edit_t e);
    reply_t      r;
    int unsigned len;
    len = text_len();
    r = '0;
    r.status = STAT_OK;
    case (e.kind)
      KIND_MOVE: begin
        if (e.position > len) r.status = STAT_RANGE;
        else slide_gap(e.position);
      end
      KIND_INSERT: begin
        if (len >= CAP) begin
          r.status = STAT_FULL;
        end else begin
          text_mem[gap_lo] = e.in_byte;
          gap_lo++;
        end
      end
      KIND_BACKSPACE: begin
        if (gap_lo > 0) gap_lo--;
      end
      KIND_REMOVE: begin
        if (e.position > len || e.count > len - e.position) begin
          r.status = STAT_RANGE;
        end else begin
          slide_gap(e.position);
          gap_hi += e.count;
        end
      end
      KIND_READ: begin
        if (e.position < len)
          r.out_byte = (e.position < gap_lo) ? text_mem[e.position]
                                             : text_mem[e.position + gap_hi - gap_lo];
      end
      default: r.status = STAT_RANGE;
    endcase
    r.text_length = POS_W'(text_len());
    r.cursor = POS_W'(gap_lo);
    return r;
  endfunction

  // sender: predicts on each accepted beat, then offers the next pending edit
  always @(posedge clk) begin : drive
    edit_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) reply_q.push_back(apply_edit(edit_on_bus));
      if (edit_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = edit_q.pop_front();
        edit_on_bus <= nxt;
        s_axis_tdata <= {3'b0, nxt.in_byte, nxt.count, nxt.position, nxt.kind};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: checks each result beat and drives tready, with one long hold-off
  always @(posedge clk) begin : observe
    reply_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status      = status_t'(m_axis_tdata[1:0]);
        got.out_byte    = m_axis_tdata[9:2];
        got.text_length = m_axis_tdata[22:10];
        got.cursor      = m_axis_tdata[35:23];
        n_replies++;
        if (reply_q.size() == 0) begin
          $error("result with no expectation: status %0d, length %0d, cursor %0d",
                 got.status, got.text_length, got.cursor);
          n_fail++;
        end else begin
          want = reply_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_fail++;
          end
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            n_fail++;
          end
          if (got.text_length !== want.text_length) begin
            $error("text_length: expected %0d, got %0d", want.text_length, got.text_length);
            n_fail++;
          end
          if (got.cursor !== want.cursor) begin
            $error("cursor: expected %0d, got %0d", want.cursor, got.cursor);
            n_fail++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_replies >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(input int unsigned op, input int unsigned position,
                      input int unsigned count, input int unsigned in_byte);
    edit_t e;
    e.kind = KIND_W'(op);
    e.position = POS_W'(position);
    e.count = POS_W'(count);
    e.in_byte = BYTE_W'(in_byte);
    edit_q.push_back(e);
  endtask

  task automatic wait_idle();
    while (edit_q.size() > 0 || s_axis_tvalid || reply_q.size() > 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned len, pos, cnt, k, pick, n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty store and short text corner cases
    send(KIND_READ, 0, 0, 0);
    send(KIND_BACKSPACE, 0, 0, 0);
    send(KIND_MOVE, 1, 0, 0);
    send(KIND_MOVE, 0, 0, 0);
    send(KIND_REMOVE, 0, 1, 0);
    send(KIND_REMOVE, 0, 0, 0);
    for (k = KIND_READ + 1; k < (1 << KIND_W); k++)
      send(k, $urandom, $urandom, $urandom);
    send(KIND_INSERT, 0, 0, 8'h00);
    send(KIND_INSERT, 0, 0, 8'hff);
    send(KIND_INSERT, 0, 0, 8'ha5);
    send(KIND_INSERT, 0, 0, 8'h5a);
    send(KIND_READ, 0, 0, 0);
    send(KIND_READ, 3, 0, 0);
    send(KIND_READ, 4, 0, 0);
    send(KIND_READ, 13'h1fff, 0, 0);
    send(KIND_MOVE, 0, 0, 0);
    send(KIND_INSERT, 0, 0, 8'h3c);
    send(KIND_MOVE, 5, 0, 0);
    send(KIND_MOVE, 6, 0, 0);
    send(KIND_MOVE, 2, 0, 0);
    send(KIND_READ, 3, 0, 0);
    send(KIND_REMOVE, 1, 2, 0);
    send(KIND_REMOVE, 1, 3, 0);
    send(KIND_REMOVE, 3, 0, 0);
    send(KIND_REMOVE, 4, 0, 0);
    send(KIND_BACKSPACE, 0, 0, 0);

    // fill to a working length, then sweep the cursor end to end
    wait_idle();
    len = text_len();
    for (k = len; k < FILL_LEN; k++) send(KIND_INSERT, 0, 0, $urandom_range(0, 255));
    send(KIND_READ, FILL_LEN - 1, 0, 0);
    send(KIND_READ, FILL_LEN, 0, 0);
    send(KIND_MOVE, 0, 0, 0);
    send(KIND_READ, 0, 0, 0);
    send(KIND_READ, FILL_LEN - 1, 0, 0);
    send(KIND_MOVE, FILL_LEN, 0, 0);
    send(KIND_MOVE, FILL_LEN + 1, 0, 0);
    send(KIND_REMOVE, 10, FILL_LEN - 9, 0);
    send(KIND_REMOVE, 10, FILL_LEN - 20, 0);
    send(KIND_REMOVE, 5, 15, 0);
    send(KIND_READ, 4, 0, 0);

    n = 0;
    while (n < N_RANDOM) begin
      if (n >= 2 * N_RANDOM / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (n >= N_RANDOM / 3) begin
        tx_idle_pct = 81;
        rx_idle_pct = 17;
      end
      while (edit_q.size() > 0) @(negedge clk);
      // one edit may still be on the bus, so this length may not yet reflect it
      len = text_len();
      pos = $urandom_range(0, len);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send($urandom_range(0, (1 << KIND_W) - 1), $urandom, $urandom, $urandom);
        n++;
      end else if (pick < 12) begin
        // replace: remove a range, then type new bytes in its place
        send(KIND_REMOVE, pos, $urandom_range(0, len - pos), 0);
        cnt = $urandom_range(1, 4);
        for (k = 0; k < cnt; k++) send(KIND_INSERT, 0, 0, $urandom_range(0, 255));
        n += cnt + 1;
      end else if (pick < 42) begin
        if (len > 300) send(KIND_REMOVE, pos, $urandom_range(0, len - pos), 0);
        else send(KIND_INSERT, 0, 0, $urandom_range(0, 255));
        n++;
      end else if (pick < 54) begin
        send(KIND_BACKSPACE, $urandom, $urandom, $urandom);
        n++;
      end else if (pick < 66) begin
        send(KIND_MOVE, (pick == 65) ? len + 1 : pos, $urandom, $urandom);
        n++;
      end else if (pick < 76) begin
        cnt = (pick == 75) ? len - pos + 1 : $urandom_range(0, len - pos);
        send(KIND_REMOVE, pos, cnt, $urandom);
        n++;
      end else begin
        send(KIND_READ, $urandom_range(0, len + 1), $urandom, $urandom);
        n++;
      end
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
